>>> hw/rtl/tcce_pkg.sv
`timescale 1ns / 1ps

package tcce_pkg;

   // cell geometry
   localparam int CELL_WIDTH  = 8;
   localparam int CELL_HEIGHT = 16;
   localparam int TAB_CELLS   = 4;
   localparam int TAB_WIDTH   = CELL_WIDTH * TAB_CELLS;
   localparam int RECT_MAX    = 63;

   localparam logic [12:0] CELL_W13  = 13'(CELL_WIDTH);
   localparam logic [12:0] CELL_H13  = 13'(CELL_HEIGHT);
   localparam logic [13:0] CELL_H14  = 14'(CELL_HEIGHT);
   localparam logic [14:0] CELL_W15  = 15'(CELL_WIDTH);
   localparam logic [14:0] TAB_W15   = 15'(TAB_WIDTH);
   localparam logic [5:0]  RECT_CELL = 6'((CELL_WIDTH > RECT_MAX) ? RECT_MAX : CELL_WIDTH);
   localparam logic [5:0]  RECT_TAB  = 6'((TAB_WIDTH > RECT_MAX) ? RECT_MAX : TAB_WIDTH);

   // character codes
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] MAX_CODE   = 8'd127;

   // commands
   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_SCROLL = 2'd1;
   localparam logic [1:0] CMD_FILL   = 2'd2;
   localparam logic [1:0] CMD_GLYPH  = 2'd3;

   // status
   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_UNSUPPORTED = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BLOCK_CODE    = 2'd2;

   localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd1024;
   localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd768;
   localparam logic [7:0]  BLOCK_CODE_RST    = 8'd219;

   typedef struct packed {
      logic [7:0]  char_code;
      logic [31:0] fg_color;
      logic [31:0] bg_color;
   } req_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [12:0] pos_x;
      logic [12:0] pos_y;
      logic [5:0]  rect_width;
      logic [31:0] color;
      logic [31:0] glyph_fg;
      logic [6:0]  glyph_code;
      logic [12:0] scroll_lines;
      logic        status;
      logic        last;
   } rsp_type;

endpackage

>>> hw/rtl/text_console_cursor_engine.sv
`timescale 1ns / 1ps

// Text console cursor engine: each request carries one character code and its
// colors; the block keeps a pixel cursor and answers with one or two commands
// (an optional scroll, then a final command flagged by last, which may be
// CMD_NONE). A request is registered in in_ff, decoded against the cursor, and
// its results land in a two-entry result register that feeds the single
// response port. The port hands out one result per cycle while rsp_stall is
// low; the next request is decoded once the last result of the previous one
// is being taken. The first result goes valid after the request has passed
// the input register and the result register. Configuration writes are always
// ready and must only be issued while no request is in flight.
module text_console_cursor_engine
   import tcce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   logic [12:0] screen_width_ff, screen_height_ff;
   logic [7:0]  block_code_ff;
   logic [12:0] cursor_x_ff, cursor_y_ff;
   logic [12:0] cursor_x_in, cursor_y_in;

   logic        in_vld_ff, in_vld_in;
   req_type     in_ff;

   rsp_type     slot_a_ff, slot_b_ff;     // a: scroll, b: final
   logic [1:0]  out_cnt_ff, out_cnt_in;

   rsp_type     scroll_res, final_res;
   logic        need_scroll;
   logic        accept, fire, rsp_take, out_free;

   assign csr_ready = 1'b1;

   assign rsp_valid = (out_cnt_ff != 2'd0);
   assign rsp_data  = (out_cnt_ff == 2'd2) ? slot_a_ff : slot_b_ff;
   assign rsp_take  = rsp_valid & ~rsp_stall;
   assign out_free  = (out_cnt_ff == 2'd0) | ((out_cnt_ff == 2'd1) & rsp_take);
   assign fire      = in_vld_ff & out_free;
   assign req_stall = in_vld_ff & ~fire;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      logic        too_short;
      logic [13:0] y_sum;
      logic [12:0] y1, y_down;
      logic        is_blk, is_fill;
      logic [14:0] fill_w;
      logic        wrap_fill, wrap_cell;
      logic [12:0] x_cell;

      too_short   = 14'(screen_height_ff) < CELL_H14;
      y_sum       = 14'(cursor_y_ff) + CELL_H14;
      need_scroll = ~too_short & (y_sum > 14'(screen_height_ff));
      y1          = need_scroll ? 13'(14'(screen_height_ff) - CELL_H14) : cursor_y_ff;
      y_down      = y1 + CELL_H13;

      is_blk  = (in_ff.char_code == block_code_ff);
      is_fill = is_blk | (in_ff.char_code == CHAR_TAB) | (in_ff.char_code == CHAR_SPACE);
      fill_w  = (!is_blk && in_ff.char_code == CHAR_TAB) ? TAB_W15 : CELL_W15;
      wrap_fill = (15'(cursor_x_ff) + fill_w) >= 15'(screen_width_ff);
      wrap_cell = (15'(cursor_x_ff) + CELL_W15) >= 15'(screen_width_ff);
      x_cell    = wrap_cell ? 13'd0 : cursor_x_ff;

      scroll_res              = '0;
      scroll_res.command      = CMD_SCROLL;
      scroll_res.color        = in_ff.bg_color;
      scroll_res.scroll_lines = 13'(y_sum - 14'(screen_height_ff));

      final_res      = '0;
      final_res.last = 1'b1;
      cursor_x_in    = cursor_x_ff;
      cursor_y_in    = y1;

      if (too_short) begin
         cursor_y_in = cursor_y_ff;
      end else if (is_fill) begin
         final_res.command    = CMD_FILL;
         final_res.pos_x      = cursor_x_ff;
         final_res.pos_y      = y1;
         final_res.rect_width = (fill_w == CELL_W15) ? RECT_CELL : RECT_TAB;
         final_res.color      = is_blk ? in_ff.fg_color : in_ff.bg_color;
         if (wrap_fill) begin
            cursor_y_in = y_down;
            cursor_x_in = 13'(fill_w);
         end else begin
            cursor_x_in = 13'(15'(cursor_x_ff) + fill_w);
         end
      end else begin
         case (in_ff.char_code)
            CHAR_NL: begin
               cursor_x_in = 13'd0;
               cursor_y_in = y_down;
            end
            CHAR_CR: begin
               cursor_x_in = 13'd0;
            end
            CHAR_BS: begin
               if (cursor_x_ff >= CELL_W13) begin
                  cursor_x_in          = cursor_x_ff - CELL_W13;
                  final_res.command    = CMD_FILL;
                  final_res.pos_x      = cursor_x_ff - CELL_W13;
                  final_res.pos_y      = y1;
                  final_res.rect_width = RECT_CELL;
                  final_res.color      = in_ff.bg_color;
               end
            end
            default: begin
               if (wrap_cell) begin
                  cursor_y_in = y_down;
               end
               cursor_x_in = x_cell;
               if (in_ff.char_code > MAX_CODE) begin
                  final_res.status = STATUS_UNSUPPORTED;
               end else begin
                  final_res.command    = CMD_GLYPH;
                  final_res.pos_x      = x_cell;
                  final_res.pos_y      = wrap_cell ? y_down : y1;
                  final_res.color      = in_ff.bg_color;
                  final_res.glyph_fg   = in_ff.fg_color;
                  final_res.glyph_code = in_ff.char_code[6:0];
                  cursor_x_in          = x_cell + CELL_W13;
               end
            end
         endcase
      end
   end

   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end

      out_cnt_in = out_cnt_ff;
      if (fire) begin
         out_cnt_in = need_scroll ? 2'd2 : 2'd1;
      end else if (rsp_take) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff        <= 1'b0;
         out_cnt_ff       <= 2'd0;
         cursor_x_ff      <= 13'd0;
         cursor_y_ff      <= 13'd0;
         screen_width_ff  <= SCREEN_WIDTH_RST;
         screen_height_ff <= SCREEN_HEIGHT_RST;
         block_code_ff    <= BLOCK_CODE_RST;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_cnt_ff <= out_cnt_in;
         if (fire) begin
            cursor_x_ff <= cursor_x_in;
            cursor_y_ff <= cursor_y_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_data;
               CSR_SCREEN_HEIGHT: screen_height_ff <= csr_data;
               CSR_BLOCK_CODE:    block_code_ff    <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      if (fire) begin
         slot_a_ff <= scroll_res;
         slot_b_ff <= final_res;
      end
   end

endmodule

>>> hw/rtl/tcce_checker.sv
`timescale 1ns / 1ps

module tcce_checker
   import tcce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a scroll is always followed directly by the final result of its request
   a_scroll_then_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid && rsp_data.last)
      else $error("scroll not followed by final result");

   // only a scroll may come without last
   a_nonlast_is_scroll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.command == CMD_SCROLL)
      else $error("non-final result is not a scroll");

   // unsupported codes draw nothing and end the request
   a_unsupported: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.command == CMD_NONE && rsp_data.last)
      else $error("unsupported status on a drawing result");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
